FILE: sv/mor_pkg.sv
// ----------------------------------------------------------------------------
// mor_pkg
// Shared constants, controller states and the command/status bundles of the
// maximal ones rectangle block.
// ----------------------------------------------------------------------------
package mor_pkg;

   localparam int CFG_W        = 10;
   localparam int AREA_W       = 19;
   localparam int AREA_MAX     = 524287;
   localparam int DEF_MAX_COLS = 512;
   localparam int DEF_MAX_ROWS = 512;

   localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;

   // register indexes of the csr port
   localparam logic REG_COL_COUNT = 1'b0;
   localparam logic REG_ROW_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_EV_READ,
      ST_EV_CMP,
      ST_EV_MAX,
      ST_ROW_END,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic ev_read;
      logic ev_push;
      logic ev_pop;
      logic ev_max;
      logic row_end;
      logic finish;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic row_last;
      logic matrix_last;
      logic ev_last;
      logic pop;
      logic clear_last;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: sv/maximal_ones_rectangle.sv
// Each item reads its column height and then writes it back; the item that ends a row
// adds the stack pass over every column plus the sentinel, with a pop and an area compare per popped bar.
// The item that ends the matrix adds the load of the result register, then a clearing
// pass over all MAX_COLS entries of the height memory during which no item is taken.
// No new item is taken until the previous one is done; read and write-back do not overlap.
// Reset: synchronous; runs the clearing pass, registers return to 512.
// ----------------------------------------------------------------------------
// maximal_ones_rectangle
// Largest all-ones rectangle of a binary matrix streamed in row-major order,
// evaluated row by row with a monotonic bar stack.
// ----------------------------------------------------------------------------
module maximal_ones_rectangle #(
   parameter int MAX_COLS = mor_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = mor_pkg::DEF_MAX_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [mor_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cell_req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mor_pkg::AREA_W-1:0] rsp_max_area
);
   import mor_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   mor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mor_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_cell_req (req_cell_req),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_max_area (rsp_max_area),
      .cmd          (cmd),
      .sts          (sts)
   );

   // an accepted item is always worked on before the next one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous item in work");

   // result register is only loaded when its slot is free
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("result overwritten before delivery");

   // datapath actions are mutually exclusive
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.update, cmd.ev_read, cmd.ev_push, cmd.ev_pop,
                cmd.ev_max, cmd.row_end, cmd.finish, cmd.clear}))
      else $error("conflicting datapath commands");

endmodule

FILE: sv/mor_ram.sv
// ----------------------------------------------------------------------------
// mor_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mor_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/mor_ctrl.sv
// ----------------------------------------------------------------------------
// mor_ctrl
// Sequencer: clearing pass, per-item height update, per-row stack
// evaluation and result hand-off.
// ----------------------------------------------------------------------------
module mor_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mor_pkg::dp_sts_type sts,
   output mor_pkg::dp_cmd_type cmd
);
   import mor_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = sts.row_last ? ST_EV_READ : ST_IDLE;
         end
         ST_EV_READ: begin
            state_in = ST_EV_CMP;
         end
         ST_EV_CMP: begin
            if (sts.pop) state_in = ST_EV_MAX;
            else if (sts.ev_last) state_in = ST_ROW_END;
            else state_in = ST_EV_READ;
         end
         ST_EV_MAX: begin
            state_in = ST_EV_CMP;
         end
         ST_ROW_END: begin
            state_in = sts.matrix_last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_CLEAR;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_EV_READ: begin
            cmd.ev_read = 1'b1;
         end
         ST_EV_CMP: begin
            cmd.ev_pop  = sts.pop;
            cmd.ev_push = !sts.pop && !sts.ev_last;
         end
         ST_EV_MAX: begin
            cmd.ev_max = 1'b1;
         end
         ST_ROW_END: begin
            cmd.row_end = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: sv/mor_dp.sv
// ----------------------------------------------------------------------------
// mor_dp
// Datapath: configuration registers, column height memory, bar stack
// memory with a cached top entry, area multiplier and result register.
// ----------------------------------------------------------------------------
module mor_dp #(
   parameter int MAX_COLS = mor_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = mor_pkg::DEF_MAX_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [mor_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                        req_cell_req,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mor_pkg::AREA_W-1:0]  rsp_max_area,
   input  mor_pkg::dp_cmd_type         cmd,
   output mor_pkg::dp_sts_type         sts
);
   import mor_pkg::*;

   localparam int CAW  = $clog2(MAX_COLS);
   localparam int IW   = $clog2(MAX_COLS + 1);
   localparam int HW   = $clog2(MAX_ROWS + 1);
   localparam int RCW  = $clog2(MAX_ROWS);
   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int PW   = HW + IW;
   localparam int XW   = (PW > AREA_W) ? PW : AREA_W;
   localparam int ECW  = (CFG_W > IW) ? CFG_W : IW;
   localparam int ERW  = (CFG_W > RW) ? CFG_W : RW;
   localparam int SEW  = CAW + HW;

   logic [CFG_W-1:0]  col_count_ff;
   logic [CFG_W-1:0]  row_count_ff;
   logic              cell_ff;
   logic [CAW-1:0]    col_ctr_ff;
   logic [RCW-1:0]    row_ctr_ff;
   logic [IW-1:0]     pos_ff;
   logic [IW-1:0]     depth_ff;
   logic [HW-1:0]     top_h_ff;
   logic [PW-1:0]     prod_ff;
   logic [AREA_W-1:0] best_ff;
   logic [CAW-1:0]    clr_ff;
   logic              rsp_valid_ff;
   logic [AREA_W-1:0] rsp_area_ff;

   logic [IW-1:0]     cols_eff;
   logic [RW-1:0]     rows_eff;
   logic [ECW-1:0]    col_ext;
   logic [ERW-1:0]    row_ext;

   logic              hgt_we;
   logic [CAW-1:0]    hgt_waddr;
   logic [HW-1:0]     hgt_wdata;
   logic              hgt_re;
   logic [CAW-1:0]    hgt_raddr;
   logic [HW-1:0]     hgt_rdata;
   logic [HW-1:0]     new_h;
   logic [HW-1:0]     h_cur;
   logic              ev_last;

   logic [SEW-1:0]    stk_wdata;
   logic [CAW-1:0]    stk_waddr;
   logic              stk_re;
   logic [CAW-1:0]    stk_raddr;
   logic [SEW-1:0]    stk_rdata;
   logic [CAW-1:0]    stk_idx;
   logic [HW-1:0]     stk_h;
   logic [IW-1:0]     depth_m2;
   logic [IW-1:0]     depth_m3;

   logic [IW-1:0]     left;
   logic [IW-1:0]     span;
   logic [XW-1:0]     prod_ext;
   logic [AREA_W-1:0] area_sat;

   // zero count acts as one, oversize count clamps to the memory size
   assign col_ext  = ECW'(col_count_ff);
   assign row_ext  = ERW'(row_count_ff);
   assign cols_eff = (col_count_ff == '0) ? IW'(1) :
                     (col_ext > ECW'(MAX_COLS)) ? IW'(MAX_COLS) : IW'(col_count_ff);
   assign rows_eff = (row_count_ff == '0) ? RW'(1) :
                     (row_ext > ERW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(row_count_ff);

   // height memory
   assign new_h     = !cell_ff ? '0 :
                      (hgt_rdata < HW'(MAX_ROWS)) ? hgt_rdata + HW'(1) : hgt_rdata;
   assign hgt_we    = cmd.update || cmd.clear;
   assign hgt_waddr = cmd.clear ? clr_ff : col_ctr_ff;
   assign hgt_wdata = cmd.clear ? '0 : new_h;
   assign hgt_re    = cmd.accept || cmd.ev_read;
   assign hgt_raddr = cmd.accept ? col_ctr_ff : pos_ff[CAW-1:0];

   mor_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_COLS)
   ) u_hgt_ram (
      .clock (clock),
      .we    (hgt_we),
      .waddr (hgt_waddr),
      .wdata (hgt_wdata),
      .re    (hgt_re),
      .raddr (hgt_raddr),
      .rdata (hgt_rdata)
   );

   // the sentinel position past the last column acts as a zero bar
   assign ev_last = (pos_ff == cols_eff);
   assign h_cur   = ev_last ? '0 : hgt_rdata;

   // stack memory, read port pre-fetches the entry below the top
   assign depth_m2  = depth_ff - IW'(2);
   assign depth_m3  = depth_ff - IW'(3);
   assign stk_waddr = depth_ff[CAW-1:0];
   assign stk_wdata = {pos_ff[CAW-1:0], h_cur};
   assign stk_re    = cmd.ev_read || cmd.ev_pop;
   assign stk_raddr = cmd.ev_pop ? depth_m3[CAW-1:0] : depth_m2[CAW-1:0];
   assign stk_idx   = stk_rdata[SEW-1:HW];
   assign stk_h     = stk_rdata[HW-1:0];

   mor_ram #(
      .WIDTH (SEW),
      .DEPTH (MAX_COLS)
   ) u_stk_ram (
      .clock (clock),
      .we    (cmd.ev_push),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign left     = (depth_ff > IW'(1)) ? IW'(stk_idx) + IW'(1) : '0;
   assign span     = pos_ff - left;
   assign prod_ext = XW'(prod_ff);
   assign area_sat = (prod_ext > XW'(AREA_MAX)) ? AREA_W'(AREA_MAX) : prod_ext[AREA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= CFG_RESET;
         row_count_ff <= CFG_RESET;
         col_ctr_ff   <= '0;
         row_ctr_ff   <= '0;
         pos_ff       <= '0;
         depth_ff     <= '0;
         best_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_COL_COUNT: col_count_ff <= csr_wdata;
               REG_ROW_COUNT: row_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.update) begin
            if (sts.row_last) begin
               col_ctr_ff <= '0;
               pos_ff     <= '0;
               depth_ff   <= '0;
            end else begin
               col_ctr_ff <= col_ctr_ff + CAW'(1);
            end
         end
         if (cmd.ev_push) begin
            depth_ff <= depth_ff + IW'(1);
            pos_ff   <= pos_ff + IW'(1);
         end
         if (cmd.ev_pop) begin
            depth_ff <= depth_ff - IW'(1);
         end
         if (cmd.ev_max && (area_sat > best_ff)) begin
            best_ff <= area_sat;
         end
         if (cmd.row_end) begin
            row_ctr_ff <= sts.matrix_last ? '0 : row_ctr_ff + RCW'(1);
         end
         if (cmd.finish) begin
            best_ff      <= '0;
            clr_ff       <= '0;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + CAW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cell_ff <= req_cell_req;
      end
      if (cmd.ev_push) begin
         top_h_ff   <= h_cur;
      end
      if (cmd.ev_pop) begin
         top_h_ff   <= stk_h;
         prod_ff    <= PW'(top_h_ff) * PW'(span);
      end
      if (cmd.finish) begin
         rsp_area_ff <= best_ff;
      end
   end

   assign sts.row_last    = (IW'(col_ctr_ff) + IW'(1)) >= cols_eff;
   assign sts.matrix_last = (RW'(row_ctr_ff) + RW'(1)) >= rows_eff;
   assign sts.ev_last     = ev_last;
   assign sts.pop         = (depth_ff != '0) && (top_h_ff >= h_cur);
   assign sts.clear_last  = (clr_ff == CAW'(MAX_COLS - 1));
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;

endmodule
